// ===== rtl/first_fit_block_allocator_unit_assert.svh =====
// Assertion macros for the first-fit block allocator.
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_UNIT_ASSERT_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_UNIT_ASSERT_SVH

// Clocked check, disabled while reset is asserted.
`define FFBA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Implication that must hold in the cycle after the trigger.
`define FFBA_ASSERT_NEXT(label, trig, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (prop)) \
        else $error(msg);

`endif

// ===== rtl/ffba_pkg.sv =====
// Package: constants, codes and types of the first-fit block allocator.
package ffba_pkg;

    localparam int MAX_BLOCKS  = 256;
    localparam int IDX_W       = $clog2(MAX_BLOCKS);
    localparam int CNT_W       = $clog2(MAX_BLOCKS + 1);
    localparam int OFFSET_BITS = 32;
    localparam int WIDE_W      = OFFSET_BITS + 2;

    localparam logic [OFFSET_BITS-1:0] HDR_BYTES = OFFSET_BITS'(16);
    localparam logic [31:0]            CAP_RESET = 32'd1048576;

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    typedef enum logic [1:0] {
        STAT_OK           = 2'd0,
        STAT_NO_SPACE     = 2'd1,
        STAT_FREE_IGNORED = 2'd2,
        STAT_TABLE_FULL   = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_HIT,
        ST_MISS
    } state_t;

    typedef struct packed {
        logic                   busy;
        logic [31:0]            size;
        logic [OFFSET_BITS-1:0] offset;
    } entry_t;

endpackage

// ===== rtl/first_fit_block_allocator_unit.sv =====
// Top level: first-fit block allocator with a sequentially scanned block table.
//
// Usage:
//   Request channel: drive action, request_size and block_address with start;
//   the beat is taken at a clock edge where start is high and busy is low.
//   Result channel: done is high for exactly one cycle with status,
//   granted_address, utilized_bytes and heap_bytes_used; the receiver must
//   take it then, there is no back-pressure.
//   Config channel: cfg_data is written to the capacity register when
//   cfg_valid and cfg_ready are high; cfg_ready is always high. Write only
//   while busy is low.
// Operation:
//   The table is walked one entry per cycle through the registered read port
//   of the block memory. A request that matches an entry ends the scan there
//   and gives done from the hit state; a miss walks every entry below the
//   count and gives done from the miss state. busy drops when done rises, so
//   a new request may be accepted at the edge that ends the done cycle; none
//   is taken while a request is still being served.
// Reset:
//   Empties the table, clears heap and user totals, capacity = 1 MiB.
//   The block memory itself is not cleared; only entries below the count
//   are read.
module first_fit_block_allocator_unit
    import ffba_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic                   action,
    input  logic [31:0]            request_size,
    input  logic [31:0]            block_address,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [31:0]            cfg_data,
    output logic                   done,
    output logic [1:0]             status,
    output logic [31:0]            granted_address,
    output logic [31:0]            utilized_bytes,
    output logic [31:0]            heap_bytes_used
);

    state_t                 state_reg, state_next;
    logic                   action_reg, action_next;
    logic [31:0]            size_reg, size_next;
    logic [31:0]            addr_reg, addr_next;
    logic [31:0]            capacity_reg;
    logic [CNT_W-1:0]       idx_reg, idx_next;
    logic [IDX_W-1:0]       chk_idx_reg, chk_idx_next;
    logic                   chk_vld_reg, chk_vld_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [OFFSET_BITS-1:0] heap_reg, heap_next;
    logic [31:0]            user_reg, user_next;
    logic                   done_reg, done_next;
    status_t                status_reg, status_next;
    logic [31:0]            grant_reg, grant_next;

    entry_t                 mem [MAX_BLOCKS];
    entry_t                 rd_data_reg;
    logic                   mem_re;
    logic                   mem_we;
    logic [IDX_W-1:0]       mem_waddr;
    entry_t                 mem_wdata;

    logic                   match_now;
    logic [OFFSET_BITS-1:0] user_addr;
    logic [WIDE_W-1:0]      append_sum;
    logic                   no_space;
    logic                   table_full;

    assign busy            = (state_reg != ST_IDLE);
    assign cfg_ready       = 1'b1;
    assign done            = done_reg;
    assign status          = status_reg;
    assign granted_address = grant_reg;
    assign utilized_bytes  = user_reg;
    assign heap_bytes_used = heap_reg;

    assign user_addr  = rd_data_reg.offset + HDR_BYTES;
    assign append_sum = {2'b00, heap_reg} + {2'b00, size_reg} + {2'b00, HDR_BYTES};
    assign no_space   = append_sum > {2'b00, capacity_reg};
    assign table_full = (count_reg == CNT_W'(MAX_BLOCKS));

    // shared compare unit: one table entry per cycle
    always_comb
    begin
        if (action_reg == ACT_ALLOC)
        begin
            match_now = chk_vld_reg && !rd_data_reg.busy && (rd_data_reg.size >= size_reg);
        end
        else
        begin
            match_now = chk_vld_reg && (user_addr == addr_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[idx_reg[IDX_W-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        action_reg  <= action_next;
        size_reg    <= size_next;
        addr_reg    <= addr_next;
        chk_idx_reg <= chk_idx_next;
        grant_reg   <= grant_next;
        status_reg  <= status_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            idx_reg      <= '0;
            chk_vld_reg  <= 1'b0;
            count_reg    <= '0;
            heap_reg     <= '0;
            user_reg     <= '0;
            done_reg     <= 1'b0;
            capacity_reg <= CAP_RESET;
        end
        else
        begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            chk_vld_reg <= chk_vld_next;
            count_reg   <= count_next;
            heap_reg    <= heap_next;
            user_reg    <= user_next;
            done_reg    <= done_next;
            if (cfg_valid && cfg_ready)
            begin
                capacity_reg <= cfg_data;
            end
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        action_next  = action_reg;
        size_next    = size_reg;
        addr_next    = addr_reg;
        idx_next     = idx_reg;
        chk_idx_next = chk_idx_reg;
        chk_vld_next = chk_vld_reg;
        count_next   = count_reg;
        heap_next    = heap_reg;
        user_next    = user_reg;
        done_next    = 1'b0;
        status_next  = status_reg;
        grant_next   = grant_reg;
        mem_re       = 1'b0;
        mem_we       = 1'b0;
        mem_waddr    = chk_idx_reg;
        mem_wdata    = rd_data_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    action_next  = action;
                    size_next    = request_size;
                    addr_next    = block_address;
                    idx_next     = '0;
                    chk_vld_next = 1'b0;
                    state_next   = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (match_now)
                begin
                    chk_vld_next = 1'b0;
                    state_next   = ST_HIT;
                end
                else if (idx_reg < count_reg)
                begin
                    mem_re       = 1'b1;
                    chk_idx_next = idx_reg[IDX_W-1:0];
                    chk_vld_next = 1'b1;
                    idx_next     = idx_reg + CNT_W'(1);
                end
                else
                begin
                    chk_vld_next = 1'b0;
                    if (!chk_vld_reg)
                    begin
                        state_next = ST_MISS;
                    end
                end
            end
            ST_HIT:
            begin
                done_next  = 1'b1;
                state_next = ST_IDLE;
                if (action_reg == ACT_ALLOC)
                begin
                    mem_we         = 1'b1;
                    mem_wdata.busy = 1'b1;
                    user_next      = user_reg + rd_data_reg.size;
                    status_next    = STAT_OK;
                    grant_next     = user_addr;
                end
                else if (rd_data_reg.busy)
                begin
                    mem_we         = 1'b1;
                    mem_wdata.busy = 1'b0;
                    user_next      = user_reg - rd_data_reg.size;
                    status_next    = STAT_OK;
                    grant_next     = '0;
                end
                else
                begin
                    status_next = STAT_FREE_IGNORED;
                    grant_next  = '0;
                end
            end
            ST_MISS:
            begin
                done_next  = 1'b1;
                state_next = ST_IDLE;
                grant_next = '0;
                priority if (action_reg == ACT_FREE)
                begin
                    status_next = STAT_FREE_IGNORED;
                end
                else if (no_space)
                begin
                    status_next = STAT_NO_SPACE;
                end
                else if (table_full)
                begin
                    status_next = STAT_TABLE_FULL;
                end
                else
                begin
                    mem_we           = 1'b1;
                    mem_waddr        = count_reg[IDX_W-1:0];
                    mem_wdata.busy   = 1'b1;
                    mem_wdata.size   = size_reg;
                    mem_wdata.offset = heap_reg;
                    count_next       = count_reg + CNT_W'(1);
                    heap_next        = append_sum[OFFSET_BITS-1:0];
                    user_next        = user_reg + size_reg;
                    status_next      = STAT_OK;
                    grant_next       = heap_reg + HDR_BYTES;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/ffba_checker.sv =====
// Port-level checker for the first-fit block allocator, bound to the top level.
`include "first_fit_block_allocator_unit_assert.svh"

module ffba_checker
    import ffba_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done,
    input logic [1:0]  status,
    input logic [31:0] granted_address
);

    `FFBA_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted beat did not raise busy")
    `FFBA_ASSERT(a_done_idle, !done || !busy, "result beat while still busy")
    `FFBA_ASSERT_NEXT(a_done_pulse, done, !done, "result strobe longer than one cycle")
    `FFBA_ASSERT(a_fail_zero, !(done && (status != STAT_OK)) || (granted_address == 32'd0), "failed request with nonzero address")

endmodule

bind first_fit_block_allocator_unit ffba_checker u_ffba_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .done            (done),
    .status          (status),
    .granted_address (granted_address)
);
